[sv/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants for the indexed max-heap
// Command and status codes, default sizes and controller/datapath signals.
// ----------------------------------------------------------------------------
`default_nettype none

package imh_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 20;
    localparam int ID_WIDTH_DEF  = 32;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;

    // Datapath operation selected by the controller for one cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,      // capture the command word
        OP_SCAN_RD,    // issue a read of the scan slot
        OP_SCAN_CHK,   // compare scan id, advance or keep the hit
        OP_NEW,        // new entry becomes cur, hole at the end, count plus one
        OP_SET_KEY,    // new key into cur
        OP_RD_ROOT,    // read the root slot
        OP_RD_LAST,    // for an extract, capture the root as result; read the last slot
        OP_TAKE_LAST,  // last entry becomes cur, count minus one
        OP_RD_PARENT,  // read parent of pos
        OP_UP_MOVE,    // parent entry down into pos, pos to parent
        OP_RD_LEFT,    // read left child
        OP_RD_RIGHT,   // keep left child, read right child
        OP_DN_MOVE,    // larger child up into pos, pos to that child
        OP_PLACE       // write cur into its resting slot
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             scan_done;   // scan reached entry count
        logic             scan_hit;    // scan id matched
        logic             empty;
        logic             full;
        logic             key_zero;
        logic             key_gt;      // new key > stored key
        logic             pos_last;    // pos is last slot
        logic             old_gt_moved;
        logic             at_root;     // pos is slot zero
        logic             up_go;       // parent key < cur key
        logic             has_left;
        logic             down_go;     // a child beats cur
    } dp_stat_t;

endpackage

`default_nettype wire

[sv/imh_if.sv]
// ----------------------------------------------------------------------------
// imh_if: valid/ready channel carrying one word
// Generic handshake interface with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface imh_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/imh_ctrl.sv]
// ----------------------------------------------------------------------------
// imh_ctrl: command sequencer for the indexed max-heap
// Steps the datapath through lookup, write and sift phases of one command.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    output logic                          res_load,
    output logic [imh_pkg::STATUS_W-1:0]  res_status,
    input  wire logic                     res_free,
    input  wire imh_pkg::dp_stat_t        stat,
    output imh_pkg::dp_cmd_t              cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_ACT,
        S_RD_LAST, S_TAKE, S_UP_RD, S_UP_CHK, S_DN_RDL, S_DN_RDR, S_DN_CHK,
        S_PLACE, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [imh_pkg::STATUS_W-1:0] st_reg, st_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd.op     = imh_pkg::OP_NONE;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = imh_pkg::OP_LATCH;
                    st_next    = imh_pkg::ST_OK;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    imh_pkg::CMD_INSERT, imh_pkg::CMD_UPDATE:
                    begin
                        state_next = S_SCAN_RD;
                    end
                    imh_pkg::CMD_EXTRACT:
                    begin
                        if (stat.empty)
                        begin
                            st_next    = imh_pkg::ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = imh_pkg::OP_RD_ROOT;
                            state_next = S_RD_LAST;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (stat.scan_done)
                begin
                    if (stat.cmd == imh_pkg::CMD_UPDATE)
                    begin
                        st_next    = imh_pkg::ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else if (stat.full)
                    begin
                        st_next    = imh_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = imh_pkg::OP_NEW;
                        state_next = S_UP_RD;
                    end
                end
                else
                begin
                    cmd.op     = imh_pkg::OP_SCAN_RD;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.op = imh_pkg::OP_SCAN_CHK;
                if (stat.scan_hit)
                begin
                    if (stat.cmd == imh_pkg::CMD_INSERT)
                    begin
                        st_next    = imh_pkg::ST_DUPLICATE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ACT;
                    end
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_ACT:
            begin
                // cur holds the found entry.
                if (stat.key_zero)
                begin
                    state_next = S_RD_LAST;
                end
                else
                begin
                    cmd.op     = imh_pkg::OP_SET_KEY;
                    state_next = stat.key_gt ? S_UP_RD : S_DN_RDL;
                end
            end
            S_RD_LAST:
            begin
                cmd.op     = imh_pkg::OP_RD_LAST;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.op = imh_pkg::OP_TAKE_LAST;
                if (stat.cmd == imh_pkg::CMD_EXTRACT)
                begin
                    state_next = S_DN_RDL;
                end
                else if (stat.pos_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = stat.old_gt_moved ? S_DN_RDL : S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                if (stat.at_root)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.op     = imh_pkg::OP_RD_PARENT;
                    state_next = S_UP_CHK;
                end
            end
            S_UP_CHK:
            begin
                if (stat.up_go)
                begin
                    cmd.op     = imh_pkg::OP_UP_MOVE;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_DN_RDL:
            begin
                if (stat.has_left)
                begin
                    cmd.op     = imh_pkg::OP_RD_LEFT;
                    state_next = S_DN_RDR;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_DN_RDR:
            begin
                cmd.op     = imh_pkg::OP_RD_RIGHT;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (stat.down_go)
                begin
                    cmd.op     = imh_pkg::OP_DN_MOVE;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.op     = imh_pkg::OP_PLACE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_status = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= imh_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> state_reg == S_IDLE)
        else $error("result load did not return to idle");
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_DECODE)
        else $error("accepted word not decoded");

endmodule

`default_nettype wire

[sv/imh_dp.sv]
// ----------------------------------------------------------------------------
// imh_dp: heap storage and working registers
// Key/id memories with one registered read and one write a cycle, position
// registers and comparators. The moving entry stays in registers during a
// sift and is written once into its resting slot.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_dp #(
    parameter int CAPACITY  = imh_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = imh_pkg::KEY_WIDTH_DEF,
    parameter int ID_WIDTH  = imh_pkg::ID_WIDTH_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int XW = AW + 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [imh_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [ID_WIDTH-1:0]           in_id,
    input  wire logic [KEY_WIDTH-1:0]          in_key,
    input  wire imh_pkg::dp_cmd_t              cmd,
    output imh_pkg::dp_stat_t                  stat,
    output logic [ID_WIDTH-1:0]                res_id,
    output logic [KEY_WIDTH-1:0]               res_key,
    output logic [CW-1:0]                      count
);

    logic [KEY_WIDTH-1:0] mem_key [CAPACITY];
    logic [ID_WIDTH-1:0]  mem_id  [CAPACITY];

    logic [imh_pkg::CMD_W-1:0] cmd_reg;
    logic [ID_WIDTH-1:0]  id_reg, cur_id_reg, left_id_reg, rd_id_reg, res_id_reg;
    logic [KEY_WIDTH-1:0] key_reg, cur_key_reg, old_key_reg, left_key_reg;
    logic [KEY_WIDTH-1:0] rd_key_reg, res_key_reg;
    logic [CW-1:0]        count_reg, scan_reg;
    logic [AW-1:0]        pos_reg, rd_addr, wr_addr, parent, last;
    logic [XW-1:0]        left_w, right_w;
    logic                 rd_en, wr_en, id_match, has_left, has_right;
    logic                 left_beats, right_beats;
    logic [KEY_WIDTH-1:0] wr_key;
    logic [ID_WIDTH-1:0]  wr_id;

    assign last    = AW'(count_reg - CW'(1));
    assign parent  = (pos_reg - AW'(1)) >> 1;
    assign left_w  = {1'b0, pos_reg, 1'b1};
    assign right_w = left_w + XW'(1);

    assign id_match    = (rd_id_reg == id_reg);
    assign has_left    = XW'(count_reg) > left_w;
    assign has_right   = XW'(count_reg) > right_w;
    // On a tie the left child wins; the right one must be strictly larger.
    assign left_beats  = left_key_reg > cur_key_reg;
    assign right_beats = has_right &&
                         (rd_key_reg > (left_beats ? left_key_reg : cur_key_reg));

    // Memory port address and write selection.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pos_reg;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_key  = cur_key_reg;
        wr_id   = cur_id_reg;
        case (cmd.op)
            imh_pkg::OP_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(scan_reg);
            end
            imh_pkg::OP_RD_ROOT:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            imh_pkg::OP_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = last;
            end
            imh_pkg::OP_RD_PARENT:
            begin
                rd_en   = 1'b1;
                rd_addr = parent;
            end
            imh_pkg::OP_RD_LEFT:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(left_w);
            end
            imh_pkg::OP_RD_RIGHT:
            begin
                rd_en   = has_right;
                rd_addr = AW'(right_w);
            end
            imh_pkg::OP_UP_MOVE:
            begin
                wr_en  = 1'b1;
                wr_key = rd_key_reg;
                wr_id  = rd_id_reg;
            end
            imh_pkg::OP_DN_MOVE:
            begin
                wr_en  = 1'b1;
                wr_key = right_beats ? rd_key_reg : left_key_reg;
                wr_id  = right_beats ? rd_id_reg  : left_id_reg;
            end
            imh_pkg::OP_PLACE:
            begin
                wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_key[wr_addr] <= wr_key;
            mem_id[wr_addr]  <= wr_id;
        end
        if (rd_en)
        begin
            rd_key_reg <= mem_key[rd_addr];
            rd_id_reg  <= mem_id[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg  <= '0;
            cmd_reg   <= imh_pkg::CMD_INSERT;
        end
        else
        begin
            case (cmd.op)
                imh_pkg::OP_LATCH:
                begin
                    cmd_reg  <= in_cmd;
                    scan_reg <= '0;
                end
                imh_pkg::OP_SCAN_CHK:
                begin
                    if (!id_match)
                        scan_reg <= scan_reg + CW'(1);
                end
                imh_pkg::OP_NEW:       count_reg <= count_reg + CW'(1);
                imh_pkg::OP_TAKE_LAST: count_reg <= count_reg - CW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            imh_pkg::OP_LATCH:
            begin
                id_reg  <= in_id;
                key_reg <= in_key;
                pos_reg <= '0;
            end
            imh_pkg::OP_SCAN_CHK:
            begin
                if (id_match)
                begin
                    pos_reg     <= AW'(scan_reg);
                    cur_id_reg  <= rd_id_reg;
                    cur_key_reg <= rd_key_reg;
                    old_key_reg <= rd_key_reg;
                end
            end
            imh_pkg::OP_NEW:
            begin
                pos_reg     <= AW'(count_reg);
                cur_key_reg <= key_reg;
                cur_id_reg  <= id_reg;
            end
            imh_pkg::OP_SET_KEY: cur_key_reg <= key_reg;
            imh_pkg::OP_RD_LAST:
            begin
                // For an extract the read data here is the root entry.
                if (cmd_reg == imh_pkg::CMD_EXTRACT)
                begin
                    res_key_reg <= rd_key_reg;
                    res_id_reg  <= rd_id_reg;
                end
            end
            imh_pkg::OP_TAKE_LAST:
            begin
                cur_key_reg <= rd_key_reg;
                cur_id_reg  <= rd_id_reg;
            end
            imh_pkg::OP_RD_RIGHT:
            begin
                left_key_reg <= rd_key_reg;
                left_id_reg  <= rd_id_reg;
            end
            imh_pkg::OP_UP_MOVE: pos_reg <= parent;
            imh_pkg::OP_DN_MOVE: pos_reg <= right_beats ? AW'(right_w) : AW'(left_w);
            default: ;
        endcase
    end

    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.scan_done    = (scan_reg >= count_reg);
        stat.scan_hit     = id_match;
        stat.empty        = (count_reg == '0);
        stat.full         = (count_reg >= CW'(CAPACITY));
        stat.key_zero     = (key_reg == '0);
        stat.key_gt       = (key_reg > old_key_reg);
        stat.pos_last     = (pos_reg == last);
        stat.old_gt_moved = (old_key_reg > rd_key_reg);
        stat.at_root      = (pos_reg == '0);
        stat.up_go        = (rd_key_reg < cur_key_reg);
        stat.has_left     = has_left;
        stat.down_go      = left_beats || right_beats;
    end

    assign res_id  = res_id_reg;
    assign res_key = res_key_reg;
    assign count   = count_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == imh_pkg::OP_NEW |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow count");
    a_swap_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == imh_pkg::OP_UP_MOVE |-> pos_reg != '0)
        else $error("sift up past root");

endmodule

`default_nettype wire

[sv/imh_fix.sv]
// ----------------------------------------------------------------------------
// imh_fix: result word output register
// Holds the valid flag and status of the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_fix (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [imh_pkg::STATUS_W-1:0] status_in,
    output logic [imh_pkg::STATUS_W-1:0]      status_out,
    output logic                              valid_out,
    input  wire logic                         ready_in
);
    logic                         valid_reg;
    logic [imh_pkg::STATUS_W-1:0] status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready_in)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) status_reg <= status_in;
    end

    assign status_out = status_reg;
    assign valid_out  = valid_reg;
endmodule

`default_nettype wire

[sv/indexed_max_heap.sv]
// ----------------------------------------------------------------------------
// indexed_max_heap: id-addressed binary max-heap
// Insert, update-by-id (a zero key removes the entry) and extract-max over a fixed-capacity heap.
// ----------------------------------------------------------------------------
//  channel   dir  word
//  in_ch     in   command, item_id, key
//  out_ch    out  status, out_id, out_key, occupancy
//
// One command is worked at a time; the input is ready only in the idle state.
// An id lookup scans the heap slot by slot, with a read and a check per slot;
// a sift reads and checks the parent per level going up, and reads the left
// child, then the right child, and checks per level going down. The single
// read port of the heap memory paces both. Reset empties the heap at once,
// no clearing pass. The result word waits in an output register; a stalled
// output holds the controller in its final state.
`default_nettype none

module indexed_max_heap #(
    parameter int CAPACITY  = imh_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = imh_pkg::KEY_WIDTH_DEF,
    parameter int ID_WIDTH  = imh_pkg::ID_WIDTH_DEF,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic clk,
    input  wire logic rst_n,
    imh_if.sink       in_ch,
    imh_if.source     out_ch
);
    // Input word: {command, item_id, key}; output word:
    // {status, out_id, out_key, occupancy}.
    imh_pkg::dp_cmd_t  cmd;
    imh_pkg::dp_stat_t stat;
    logic res_load, res_free;
    logic [imh_pkg::STATUS_W-1:0] res_status, st_out;
    logic [ID_WIDTH-1:0]  dp_id, id_out_reg;
    logic [KEY_WIDTH-1:0] dp_key, key_out_reg;
    logic [CW-1:0]        count, occ_reg;
    logic                 ok_ext;

    imh_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .res_load, .res_status, .res_free,
        .stat, .cmd
    );

    imh_dp #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .ID_WIDTH(ID_WIDTH)) u_dp (
        .clk, .rst_n,
        .in_cmd(in_ch.data[KEY_WIDTH+ID_WIDTH +: imh_pkg::CMD_W]),
        .in_id(in_ch.data[KEY_WIDTH +: ID_WIDTH]),
        .in_key(in_ch.data[KEY_WIDTH-1:0]),
        .cmd, .stat, .res_id(dp_id), .res_key(dp_key), .count
    );

    imh_fix u_fix (
        .clk, .rst_n, .load(res_load), .status_in(res_status),
        .status_out(st_out), .valid_out(out_ch.valid), .ready_in(out_ch.ready)
    );

    // A new result may load when the register is empty or being taken.
    assign res_free = !out_ch.valid || out_ch.ready;
    // Only a successful extract reports an entry; every other word carries a zero id and key.
    assign ok_ext   = (stat.cmd == imh_pkg::CMD_EXTRACT) && (res_status == imh_pkg::ST_OK);

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            id_out_reg  <= ok_ext ? dp_id : '0;
            key_out_reg <= ok_ext ? dp_key : '0;
            occ_reg     <= count;
        end
    end

    assign out_ch.data = {st_out, id_out_reg, key_out_reg, occ_reg};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> res_free)
        else $error("result overwritten");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> st_out <= imh_pkg::ST_DUPLICATE)
        else $error("bad status code");

endmodule

`default_nettype wire
